// ===== hdl/assert_macros.svh =====
// Assertion macros used by the drag block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// ===== hdl/edtf_pkg.sv =====
// Constants, types and fixed-point helpers for the edge drag tensor block.
package edtf_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 24;
    localparam int COEF_W     = 31;
    localparam int NORM_IN_W  = 34;
    localparam int UNIT_W     = 26;
    localparam int SQRT_STEPS = 32;
    localparam int QUO_BITS   = 25;
    // r1..r6, square root steps, divide setup, divide steps, output
    localparam int NORM_LAT   = 6 + SQRT_STEPS + 1 + QUO_BITS + 1;
    localparam int PAIRS      = 6;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [71:0]          prod_t;
    typedef logic signed [47:0]          rnd_t;
    typedef logic signed [49:0]          acc_t;

    // register index codes
    localparam logic [1:0] REG_CLIMB = 2'd0;
    localparam logic [1:0] REG_LINE  = 2'd1;
    localparam logic [1:0] REG_GLIDE = 2'd2;

    // upper triangle of a symmetric 3x3 matrix
    localparam int PAIR_I [PAIRS] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_J [PAIRS] = '{0, 1, 2, 1, 2, 2};

    localparam prod_t RND_HALF    = 72'sd8388608;
    localparam prod_t RND_HALF_M1 = 72'sd8388607;
    localparam acc_t  SAT_MAX     = 50'sd2147483647;
    localparam acc_t  SAT_MIN     = -50'sd2147483648;

    // Map a row and column to the stored upper-triangle entry.
    function automatic int sym_idx(input int i, input int j);
        int a;
        int b;
        a = (i < j) ? i : j;
        b = (i < j) ? j : i;
        return (a == 0) ? b : ((a == 1) ? (b + 2) : 5);
    endfunction

    // Divide a product by 2^24, rounding halves away from zero.
    function automatic rnd_t round_fx(input prod_t p);
        prod_t t;
        t = p + (p[71] ? RND_HALF_M1 : RND_HALF);
        return t[71:24];
    endfunction

    // Clamp a sum to a signed word.
    function automatic word_t sat_word(input acc_t v);
        word_t r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/edtf_norm.sv =====
// Pipelined 3-vector normalizer: scale, square root and divide, one vector per cycle while adv is high.
module edtf_norm (
    input  logic                                  aclk,
    input  logic                                  adv,
    input  logic signed [edtf_pkg::NORM_IN_W-1:0] in_vec  [3],
    output logic signed [edtf_pkg::UNIT_W-1:0]    out_vec [3]
);

    localparam int MW = edtf_pkg::NORM_IN_W;
    localparam int SQ = edtf_pkg::SQRT_STEPS;
    localparam int QB = edtf_pkg::QUO_BITS;

    // stage 1: magnitudes
    logic [MW-1:0] mag1_reg [3];
    logic          neg1_reg [3];
    // stage 2: largest magnitude
    logic [MW-1:0] mag2_reg [3];
    logic          neg2_reg [3];
    logic [MW-1:0] max2_reg;
    // stage 3: shift amount
    logic [MW-1:0] mag3_reg [3];
    logic          neg3_reg [3];
    logic          zero3_reg;
    logic          right3_reg;
    logic [5:0]    amt3_reg;
    // stage 4: scaled magnitudes
    logic [30:0]   sh4_reg [3];
    logic          neg4_reg [3];
    logic          zero4_reg;
    // stage 5: squares
    logic [61:0]   sq5_reg [3];
    logic [30:0]   sh5_reg [3];
    logic          neg5_reg [3];
    logic          zero5_reg;
    // square root steps, entry 0 holds the sum of squares
    logic [63:0]   sr_s_reg    [SQ+1];
    logic [63:0]   sr_res_reg  [SQ+1];
    logic [30:0]   sr_m_reg    [SQ+1][3];
    logic          sr_neg_reg  [SQ+1][3];
    logic          sr_zero_reg [SQ+1];
    logic [63:0]   sr_s_next   [SQ];
    logic [63:0]   sr_res_next [SQ];
    // divide steps, entry 0 holds the setup
    logic [31:0]   dv_rem_reg  [QB+1][3];
    logic [QB-1:0] dv_low_reg  [QB+1][3];
    logic [QB-1:0] dv_q_reg    [QB+1][3];
    logic [31:0]   dv_len_reg  [QB+1];
    logic          dv_neg_reg  [QB+1][3];
    logic          dv_zero_reg [QB+1];
    logic [31:0]   dv_rem_next [QB][3];
    logic [QB-1:0] dv_q_next   [QB][3];
    logic signed [edtf_pkg::UNIT_W-1:0] out_reg [3];

    logic [MW-1:0] max_next;
    logic [5:0]    pos_next;
    logic [30:0]   sh_next  [3];
    logic [55:0]   num_next [3];
    logic [63:0]   wide_sh  [3];

    // find the largest magnitude
    always_comb begin
        max_next = mag1_reg[0];
        if (mag1_reg[1] > max_next) begin
            max_next = mag1_reg[1];
        end
        if (mag1_reg[2] > max_next) begin
            max_next = mag1_reg[2];
        end
    end

    // locate the leading one of the largest magnitude
    always_comb begin
        pos_next = '0;
        for (int b = 0; b < MW; b++) begin
            if (max2_reg[b]) begin
                pos_next = 6'(b);
            end
        end
    end

    // scale all magnitudes by the common shift
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wide_sh[i] = 64'(mag3_reg[i]) << amt3_reg;
            if (right3_reg) begin
                sh_next[i] = 31'(mag3_reg[i] >> amt3_reg);
            end else begin
                sh_next[i] = wide_sh[i][30:0];
            end
        end
    end

    // one result digit per square root step
    always_comb begin
        logic [63:0] bitv;
        logic [64:0] trial;
        for (int k = 0; k < SQ; k++) begin
            bitv  = 64'd1 << (7'(62 - 2 * k));
            trial = {1'b0, sr_res_reg[k]} + {1'b0, bitv};
            if ({1'b0, sr_s_reg[k]} >= trial) begin
                sr_s_next[k]   = sr_s_reg[k] - trial[63:0];
                sr_res_next[k] = (sr_res_reg[k] >> 1) + bitv;
            end else begin
                sr_s_next[k]   = sr_s_reg[k];
                sr_res_next[k] = sr_res_reg[k] >> 1;
            end
        end
    end

    // rounded numerator for the divide
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_next[i] = {sr_m_reg[SQ][i], 24'd0}
                        + 56'(sr_res_reg[SQ][31:1]);
        end
    end

    // one quotient bit per divide step
    always_comb begin
        logic [32:0] t;
        for (int k = 0; k < QB; k++) begin
            for (int i = 0; i < 3; i++) begin
                t = {dv_rem_reg[k][i], dv_low_reg[k][i][QB-1]};
                if (t >= {1'b0, dv_len_reg[k]}) begin
                    dv_rem_next[k][i] = 32'(t - {1'b0, dv_len_reg[k]});
                    dv_q_next[k][i]   = {dv_q_reg[k][i][QB-2:0], 1'b1};
                end else begin
                    dv_rem_next[k][i] = t[31:0];
                    dv_q_next[k][i]   = {dv_q_reg[k][i][QB-2:0], 1'b0};
                end
            end
        end
    end

    // advance the whole pipe together
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                neg1_reg[i] <= in_vec[i][MW-1];
                mag1_reg[i] <= in_vec[i][MW-1] ? MW'(-in_vec[i]) : MW'(in_vec[i]);
                mag2_reg[i] <= mag1_reg[i];
                neg2_reg[i] <= neg1_reg[i];
                mag3_reg[i] <= mag2_reg[i];
                neg3_reg[i] <= neg2_reg[i];
                sh4_reg[i]  <= sh_next[i];
                neg4_reg[i] <= neg3_reg[i];
                sq5_reg[i]  <= sh4_reg[i] * sh4_reg[i];
                sh5_reg[i]  <= sh4_reg[i];
                neg5_reg[i] <= neg4_reg[i];
                sr_m_reg[0][i]   <= sh5_reg[i];
                sr_neg_reg[0][i] <= neg5_reg[i];
            end
            max2_reg   <= max_next;
            zero3_reg  <= (max2_reg == '0);
            right3_reg <= (pos_next > 6'd30);
            amt3_reg   <= (pos_next > 6'd30) ? (pos_next - 6'd30) : (6'd30 - pos_next);
            zero4_reg  <= zero3_reg;
            zero5_reg  <= zero4_reg;
            sr_s_reg[0]    <= 64'(sq5_reg[0]) + 64'(sq5_reg[1]) + 64'(sq5_reg[2]);
            sr_res_reg[0]  <= '0;
            sr_zero_reg[0] <= zero5_reg;
            for (int k = 0; k < SQ; k++) begin
                sr_s_reg[k+1]    <= sr_s_next[k];
                sr_res_reg[k+1]  <= sr_res_next[k];
                sr_zero_reg[k+1] <= sr_zero_reg[k];
                for (int i = 0; i < 3; i++) begin
                    sr_m_reg[k+1][i]   <= sr_m_reg[k][i];
                    sr_neg_reg[k+1][i] <= sr_neg_reg[k][i];
                end
            end
            dv_len_reg[0]  <= sr_res_reg[SQ][31:0];
            dv_zero_reg[0] <= sr_zero_reg[SQ];
            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= 32'(num_next[i][55:25]);
                dv_low_reg[0][i] <= num_next[i][24:0];
                dv_q_reg[0][i]   <= '0;
                dv_neg_reg[0][i] <= sr_neg_reg[SQ][i];
            end
            for (int k = 0; k < QB; k++) begin
                dv_len_reg[k+1]  <= dv_len_reg[k];
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                for (int i = 0; i < 3; i++) begin
                    dv_rem_reg[k+1][i] <= dv_rem_next[k][i];
                    dv_low_reg[k+1][i] <= dv_low_reg[k][i] << 1;
                    dv_q_reg[k+1][i]   <= dv_q_next[k][i];
                    dv_neg_reg[k+1][i] <= dv_neg_reg[k][i];
                end
            end
            // put the sign back, zero vector stays zero
            for (int i = 0; i < 3; i++) begin
                if (dv_zero_reg[QB]) begin
                    out_reg[i] <= '0;
                end else if (dv_neg_reg[QB][i]) begin
                    out_reg[i] <= -$signed({1'b0, dv_q_reg[QB][i]});
                end else begin
                    out_reg[i] <= $signed({1'b0, dv_q_reg[QB][i]});
                end
            end
        end
    end

    assign out_vec = out_reg;

endmodule

// ===== hdl/edge_drag_tensor_and_force.sv =====
// Throughput: one request per cycle unless a held result stalls the pipe; the normalizers'
// 32-step square root and 25-step divide pipelines set the depth.
// A result held at the output stalls every stage and the input together.
// Reset (aresetn low at a clock edge) clears all valid bits and the coefficients.
`include "assert_macros.svh"

// Top level: two normalizers, cross product, drag matrix and force pipeline.
module edge_drag_tensor_and_force (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [30:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_vel_x,
    input  logic signed [31:0]   s_vel_y,
    input  logic signed [31:0]   s_vel_z,
    input  logic signed [31:0]   s_burgers_x,
    input  logic signed [31:0]   s_burgers_y,
    input  logic signed [31:0]   s_burgers_z,
    input  logic signed [31:0]   s_dir_x,
    input  logic signed [31:0]   s_dir_y,
    input  logic signed [31:0]   s_dir_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_force_x,
    output logic signed [31:0]   m_force_y,
    output logic signed [31:0]   m_force_z,
    output logic signed [31:0]   m_m00,
    output logic signed [31:0]   m_m01,
    output logic signed [31:0]   m_m02,
    output logic signed [31:0]   m_m10,
    output logic signed [31:0]   m_m11,
    output logic signed [31:0]   m_m12,
    output logic signed [31:0]   m_m20,
    output logic signed [31:0]   m_m21,
    output logic signed [31:0]   m_m22
);

    localparam int NL = edtf_pkg::NORM_LAT;
    localparam int NP = edtf_pkg::PAIRS;
    localparam int UW = edtf_pkg::UNIT_W;
    localparam int NW = edtf_pkg::NORM_IN_W;

    logic adv;

    logic [edtf_pkg::COEF_W-1:0] cc_coef_reg;
    logic [edtf_pkg::COEF_W-1:0] cl_coef_reg;
    logic [edtf_pkg::COEF_W-1:0] cg_coef_reg;

    // first delay line, entry 0 is the input register
    logic                dl_valid_reg [NL+1];
    edtf_pkg::word_t     dl_v_reg     [NL+1][3];
    edtf_pkg::word_t     dl_d_reg     [NL+1][3];
    edtf_pkg::word_t     in_b_reg     [3];
    logic signed [NW-1:0] b_ext       [3];
    logic signed [UW-1:0] g_vec       [3];

    // cross product stages
    logic                a_valid_reg;
    logic signed [57:0]  a_pa_reg [3];
    logic signed [57:0]  a_pb_reg [3];
    edtf_pkg::word_t     a_d_reg  [3];
    edtf_pkg::word_t     a_v_reg  [3];
    logic signed [UW-1:0] a_g_reg [3];
    logic signed [NW-1:0] x_reg   [3];
    edtf_pkg::rnd_t      xa_rnd   [3];
    edtf_pkg::rnd_t      xb_rnd   [3];

    // second delay line, entry 0 lines up with the cross product register
    logic                ev_valid_reg [NL+1];
    edtf_pkg::word_t     ev_v_reg     [NL+1][3];
    edtf_pkg::word_t     ev_d_reg     [NL+1][3];
    logic signed [UW-1:0] ev_g_reg    [NL+1][3];
    logic signed [UW-1:0] c_vec       [3];

    // matrix and force stages
    logic                b_valid_reg [1:9];
    edtf_pkg::word_t     b_v_reg     [1:6][3];
    logic signed [51:0]  b1_cc_reg [NP];
    logic signed [63:0]  b1_dd_reg [NP];
    logic signed [51:0]  b1_gg_reg [NP];
    logic signed [25:0]  b2_cc_reg [NP];
    logic signed [39:0]  b2_dd_reg [NP];
    logic signed [25:0]  b2_gg_reg [NP];
    logic signed [57:0]  b3_pc_reg [NP];
    logic signed [57:0]  b3_pg_reg [NP];
    logic signed [64:0]  b3_plo_reg [NP];
    logic signed [39:0]  b3_phi_reg [NP];
    logic signed [57:0]  b4_pc_reg [NP];
    logic signed [57:0]  b4_pg_reg [NP];
    edtf_pkg::prod_t     b4_pd_reg [NP];
    edtf_pkg::rnd_t      b5_tc_reg [NP];
    edtf_pkg::rnd_t      b5_td_reg [NP];
    edtf_pkg::rnd_t      b5_tg_reg [NP];
    edtf_pkg::word_t     b6_mat_reg [NP];
    edtf_pkg::word_t     b7_mat_reg [NP];
    logic signed [63:0]  b7_fp_reg  [9];
    edtf_pkg::word_t     b8_mat_reg [NP];
    edtf_pkg::rnd_t      b8_fr_reg  [9];
    edtf_pkg::word_t     out_mat_reg [NP];
    edtf_pkg::word_t     out_f_reg   [3];

    logic signed [32:0]  cc_s;
    logic signed [32:0]  cl_s;
    logic signed [32:0]  cg_s;

    // the whole pipe moves unless a result is held
    assign adv     = !b_valid_reg[9] || m_ready;
    assign s_ready = adv;

    // coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_coef_reg <= '0;
            cl_coef_reg <= '0;
            cg_coef_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                edtf_pkg::REG_CLIMB: cc_coef_reg <= cfg_wdata;
                edtf_pkg::REG_LINE:  cl_coef_reg <= cfg_wdata;
                edtf_pkg::REG_GLIDE: cg_coef_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NL; k++) begin
                dl_valid_reg[k] <= 1'b0;
                ev_valid_reg[k] <= 1'b0;
            end
            a_valid_reg <= 1'b0;
            for (int k = 1; k <= 9; k++) begin
                b_valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            dl_valid_reg[0] <= s_valid;
            for (int k = 0; k < NL; k++) begin
                dl_valid_reg[k+1] <= dl_valid_reg[k];
                ev_valid_reg[k+1] <= ev_valid_reg[k];
            end
            a_valid_reg     <= dl_valid_reg[NL];
            ev_valid_reg[0] <= a_valid_reg;
            b_valid_reg[1]  <= ev_valid_reg[NL];
            for (int k = 1; k < 9; k++) begin
                b_valid_reg[k+1] <= b_valid_reg[k];
            end
        end
    end

    // glide direction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            b_ext[i] = NW'(in_b_reg[i]);
        end
    end

    edtf_norm u_norm_glide (
        .aclk    (aclk),
        .adv     (adv),
        .in_vec  (b_ext),
        .out_vec (g_vec)
    );

    // round the cross product terms
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            xa_rnd[i] = edtf_pkg::round_fx(72'(a_pa_reg[i]));
            xb_rnd[i] = edtf_pkg::round_fx(72'(a_pb_reg[i]));
        end
    end

    edtf_norm u_norm_climb (
        .aclk    (aclk),
        .adv     (adv),
        .in_vec  (x_reg),
        .out_vec (c_vec)
    );

    assign cc_s = $signed({2'b00, cc_coef_reg});
    assign cl_s = $signed({2'b00, cl_coef_reg});
    assign cg_s = $signed({2'b00, cg_coef_reg});

    // payload pipeline
    always_ff @(posedge aclk) begin
        if (adv) begin
            // capture the request
            dl_v_reg[0][0] <= s_vel_x;
            dl_v_reg[0][1] <= s_vel_y;
            dl_v_reg[0][2] <= s_vel_z;
            dl_d_reg[0][0] <= s_dir_x;
            dl_d_reg[0][1] <= s_dir_y;
            dl_d_reg[0][2] <= s_dir_z;
            in_b_reg[0]    <= s_burgers_x;
            in_b_reg[1]    <= s_burgers_y;
            in_b_reg[2]    <= s_burgers_z;
            for (int k = 0; k < NL; k++) begin
                for (int i = 0; i < 3; i++) begin
                    dl_v_reg[k+1][i] <= dl_v_reg[k][i];
                    dl_d_reg[k+1][i] <= dl_d_reg[k][i];
                    ev_v_reg[k+1][i] <= ev_v_reg[k][i];
                    ev_d_reg[k+1][i] <= ev_d_reg[k][i];
                    ev_g_reg[k+1][i] <= ev_g_reg[k][i];
                end
            end
            // cross product d x g
            for (int i = 0; i < 3; i++) begin
                a_pa_reg[i] <= dl_d_reg[NL][(i + 1) % 3] * g_vec[(i + 2) % 3];
                a_pb_reg[i] <= dl_d_reg[NL][(i + 2) % 3] * g_vec[(i + 1) % 3];
                a_d_reg[i]  <= dl_d_reg[NL][i];
                a_v_reg[i]  <= dl_v_reg[NL][i];
                a_g_reg[i]  <= g_vec[i];
                x_reg[i]    <= NW'(xa_rnd[i] - xb_rnd[i]);
                ev_d_reg[0][i] <= a_d_reg[i];
                ev_v_reg[0][i] <= a_v_reg[i];
                ev_g_reg[0][i] <= a_g_reg[i];
            end
            // velocity rides along with the matrix stages
            for (int i = 0; i < 3; i++) begin
                b_v_reg[1][i] <= ev_v_reg[NL][i];
                for (int k = 1; k < 6; k++) begin
                    b_v_reg[k+1][i] <= b_v_reg[k][i];
                end
            end
            for (int p = 0; p < NP; p++) begin
                // outer products
                b1_cc_reg[p] <= c_vec[edtf_pkg::PAIR_I[p]] * c_vec[edtf_pkg::PAIR_J[p]];
                b1_dd_reg[p] <= ev_d_reg[NL][edtf_pkg::PAIR_I[p]]
                              * ev_d_reg[NL][edtf_pkg::PAIR_J[p]];
                b1_gg_reg[p] <= ev_g_reg[NL][edtf_pkg::PAIR_I[p]]
                              * ev_g_reg[NL][edtf_pkg::PAIR_J[p]];
                b2_cc_reg[p] <= 26'(edtf_pkg::round_fx(72'(b1_cc_reg[p])));
                b2_dd_reg[p] <= 40'(edtf_pkg::round_fx(72'(b1_dd_reg[p])));
                b2_gg_reg[p] <= 26'(edtf_pkg::round_fx(72'(b1_gg_reg[p])));
                // weight by the coefficients, line term in two parts
                b3_pc_reg[p]  <= 58'(cc_s * b2_cc_reg[p]);
                b3_pg_reg[p]  <= 58'(cg_s * b2_gg_reg[p]);
                b3_plo_reg[p] <= 65'(cl_s * $signed({1'b0, b2_dd_reg[p][31:0]}));
                b3_phi_reg[p] <= 40'(cl_s * $signed(b2_dd_reg[p][39:32]));
                b4_pc_reg[p]  <= b3_pc_reg[p];
                b4_pg_reg[p]  <= b3_pg_reg[p];
                b4_pd_reg[p]  <= (72'(b3_phi_reg[p]) <<< 32) + 72'(b3_plo_reg[p]);
                b5_tc_reg[p]  <= edtf_pkg::round_fx(72'(b4_pc_reg[p]));
                b5_td_reg[p]  <= edtf_pkg::round_fx(b4_pd_reg[p]);
                b5_tg_reg[p]  <= edtf_pkg::round_fx(72'(b4_pg_reg[p]));
                b6_mat_reg[p] <= edtf_pkg::sat_word(50'(b5_tc_reg[p]) + 50'(b5_td_reg[p])
                                                  + 50'(b5_tg_reg[p]));
                b7_mat_reg[p]  <= b6_mat_reg[p];
                b8_mat_reg[p]  <= b7_mat_reg[p];
                out_mat_reg[p] <= b8_mat_reg[p];
            end
            // force = M * v
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    b7_fp_reg[3 * i + j] <= b6_mat_reg[edtf_pkg::sym_idx(i, j)]
                                          * b_v_reg[6][j];
                    b8_fr_reg[3 * i + j] <= edtf_pkg::round_fx(72'(b7_fp_reg[3 * i + j]));
                end
                out_f_reg[i] <= edtf_pkg::sat_word(50'(b8_fr_reg[3 * i])
                                                 + 50'(b8_fr_reg[3 * i + 1])
                                                 + 50'(b8_fr_reg[3 * i + 2]));
            end
        end
    end

    assign m_valid   = b_valid_reg[9];
    assign m_force_x = out_f_reg[0];
    assign m_force_y = out_f_reg[1];
    assign m_force_z = out_f_reg[2];
    assign m_m00     = out_mat_reg[0];
    assign m_m01     = out_mat_reg[1];
    assign m_m02     = out_mat_reg[2];
    assign m_m10     = out_mat_reg[1];
    assign m_m11     = out_mat_reg[3];
    assign m_m12     = out_mat_reg[4];
    assign m_m20     = out_mat_reg[2];
    assign m_m21     = out_mat_reg[4];
    assign m_m22     = out_mat_reg[5];

    // the drag matrix is symmetric
    `ASSERT_IMP(a_mat_sym, m_valid,
        (m_m01 == m_m10) && (m_m02 == m_m20) && (m_m12 == m_m21),
        "drag matrix lost its symmetry")

    // all diagonal terms are sums of non-negative parts
    `ASSERT_IMP(a_diag_pos, m_valid,
        !m_m00[31] && !m_m11[31] && !m_m22[31],
        "negative diagonal drag entry")

    // a normalized glide direction stays within unit length per component
    `ASSERT_IMP(a_glide_unit, dl_valid_reg[NL],
        (g_vec[0] <= 26'sd16777216) && (g_vec[0] >= -26'sd16777216) &&
        (g_vec[1] <= 26'sd16777216) && (g_vec[1] >= -26'sd16777216) &&
        (g_vec[2] <= 26'sd16777216) && (g_vec[2] >= -26'sd16777216),
        "glide direction component out of range")

endmodule

// ===== dv/edge_drag_tensor_and_force_tb.sv =====
// Self-checking testbench for the edge drag tensor and force block.
`timescale 1ns / 100ps

module edge_drag_tensor_and_force_tb;

    // index that decodes to no register
    localparam logic [1:0] REG_NONE = 2'd3;
    localparam longint unsigned PROD_CAP = 64'd1 << 60;
    localparam int LATENCY = 141;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 400;

    typedef logic [8:0][31:0]  drag_req_t;
    typedef logic [11:0][31:0] drag_res_t;
    typedef longint vec3_t [3];

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = edtf_pkg::REG_CLIMB;
    logic [30:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_vel_x = '0, s_vel_y = '0, s_vel_z = '0;
    logic signed [31:0] s_burgers_x = '0, s_burgers_y = '0, s_burgers_z = '0;
    logic signed [31:0] s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_force_x, m_force_y, m_force_z;
    logic signed [31:0] m_m00, m_m01, m_m02, m_m10, m_m11, m_m12, m_m20, m_m21, m_m22;

    edge_drag_tensor_and_force dut (.*);

    always #5 aclk = ~aclk;

    // coefficient copies, expected drag results, bookkeeping
    longint coef_climb = 0, coef_line = 0, coef_glide = 0;
    drag_res_t drag_expected [$];
    int errors = 0;
    int cycles = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int cfg_phases = 0;
    int ready_stall = 0;
    bit burst_mode = 1'b0;
    bit long_hold_req = 1'b0;
    string res_name [12] = '{"force_x", "force_y", "force_z", "m00", "m01", "m02",
                             "m10", "m11", "m12", "m20", "m21", "m22"};

    // Rounded Q8.24 product, magnitude capped.
    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] p;
        longint unsigned ua, ub, r;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        p = (p + 128'd8388608) >> 24;
        r = (p > {64'd0, PROD_CAP}) ? PROD_CAP : p[63:0];
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [31:0] clamp_word(input longint v);
        logic [31:0] r;
        if (v > 64'sd2147483647) r = 32'h7fffffff;
        else if (v < -64'sd2147483648) r = 32'h80000000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Scale to unit length; a zero vector stays zero.
    function automatic vec3_t unit_vec(input vec3_t v);
        longint unsigned m [3];
        longint unsigned mx, s, len, q;
        vec3_t u;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return '{0, 0, 0};
        while (mx >= (64'd1 << 31)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 24) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return u;
    endfunction

    // Drag matrix and force for one request.
    function automatic drag_res_t drag_predict(input drag_req_t rq);
        vec3_t v, b, d, g, x, c;
        longint mat [3][3];
        longint t;
        drag_res_t r;
        for (int i = 0; i < 3; i++) begin
            v[i] = $signed(rq[i]);
            b[i] = $signed(rq[3 + i]);
            d[i] = $signed(rq[6 + i]);
        end
        g = unit_vec(b);
        x[0] = fx_mul(d[1], g[2]) - fx_mul(d[2], g[1]);
        x[1] = fx_mul(d[2], g[0]) - fx_mul(d[0], g[2]);
        x[2] = fx_mul(d[0], g[1]) - fx_mul(d[1], g[0]);
        c = unit_vec(x);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                t = fx_mul(coef_climb, fx_mul(c[i], c[j]))
                  + fx_mul(coef_line, fx_mul(d[i], d[j]))
                  + fx_mul(coef_glide, fx_mul(g[i], g[j]));
                r[3 + i * 3 + j] = clamp_word(t);
                mat[i][j] = $signed(r[3 + i * 3 + j]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            t = fx_mul(mat[i][0], v[0]) + fx_mul(mat[i][1], v[1]) + fx_mul(mat[i][2], v[2]);
            r[i] = clamp_word(t);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // Offer one request, hold it until accepted, then queue its expectation.
    task automatic send_request(input drag_req_t rq);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        {s_dir_z, s_dir_y, s_dir_x, s_burgers_z, s_burgers_y, s_burgers_x,
         s_vel_z, s_vel_y, s_vel_x} <= rq;
        do @(posedge aclk); while (!s_ready);
        drag_expected.push_back(drag_predict(rq));
        requests_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (drag_expected.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // Write one register, keeping the local copy in step.
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            edtf_pkg::REG_CLIMB: coef_climb = longint'(val);
            edtf_pkg::REG_LINE:  coef_line = longint'(val);
            edtf_pkg::REG_GLIDE: coef_glide = longint'(val);
            default: ;
        endcase
    endtask

    task automatic set_coefs(input logic [30:0] cc, input logic [30:0] cl,
                             input logic [30:0] cg);
        drain();
        write_reg(edtf_pkg::REG_CLIMB, cc);
        write_reg(edtf_pkg::REG_LINE, cl);
        write_reg(edtf_pkg::REG_GLIDE, cg);
        cfg_phases++;
    endtask

    function automatic logic [31:0] rand_field();
        logic signed [31:0] t;
        logic [31:0] picks [7] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h1,
                                   32'hffffffff, 32'h01000000, 32'hff000000};
        t = $urandom;
        case ($urandom_range(0, 5))
            0: return t;
            1: return t >>> $urandom_range(1, 30);
            2: return picks[$urandom_range(0, 6)];
            default: return $urandom_range(0, 32'h4000000) - 32'h2000000;
        endcase
    endfunction

    // Mostly unit line directions with random content, some raw noise.
    function automatic drag_req_t rand_request();
        drag_req_t rq;
        vec3_t d;
        for (int i = 0; i < 9; i++) rq[i] = rand_field();
        if ($urandom_range(0, 9) < 7) begin
            for (int i = 0; i < 3; i++) d[i] = $signed(rq[6 + i]);
            d = unit_vec(d);
            for (int i = 0; i < 3; i++) rq[6 + i] = d[i][31:0];
        end
        if ($urandom_range(0, 19) == 0) rq[5:3] = '0;
        return rq;
    endfunction

    function automatic drag_req_t mk(input logic [31:0] vx, vy, vz, bx, by, bz,
                                     dx, dy, dz);
        return {dz, dy, dx, bz, by, bx, vz, vy, vx};
    endfunction

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        drag_res_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_m22, m_m21, m_m20, m_m12, m_m11, m_m10, m_m02, m_m01, m_m00,
                   m_force_z, m_force_y, m_force_x};
            results_seen++;
            if (drag_expected.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = drag_expected.pop_front();
                for (int k = 0; k < 12; k++)
                    if (got[k] !== want[k])
                        report_mismatch($sformatf("%s got %h want %h", res_name[k],
                                                  got[k], want[k]));
            end
            ready_stall = burst_mode ? 0 : $urandom_range(0, 4);
        end
    end

    // Drive result ready: random stalls, or one long hold on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
            end else if (ready_stall > 0) begin
                m_ready <= 1'b0;
                ready_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Zero, parallel, extreme and non-unit cases at unit, maximum and zero coefficients.
    task automatic test_directed();
        logic [31:0] one, neg1, mx, mn;
        one = 32'h01000000;
        neg1 = 32'hff000000;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        set_coefs(31'h01000000, 31'h01000000, 31'h01000000);
        send_request(mk(one, one, one, 0, 0, 0, one, 0, 0));
        send_request(mk(one, neg1, one, one, 0, 0, one, 0, 0));
        send_request(mk(one, neg1, one, neg1, 0, 0, one, 0, 0));
        send_request(mk(one, one, one, one, 0, 0, 0, one, 0));
        send_request(mk(mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_request(mk(mn, mn, mn, mn, mn, mn, mn, mn, mn));
        send_request(mk(mx, mn, mx, mn, mx, 1, 0, 0, one));
        send_request(mk(one, one, one, 1, 0, 0, 0, 0, one));
        send_request(mk(one, one, one, 1, 1, 1, 0, one, 0));
        send_request(mk(one, 2 * one, 3 * one, 3 * one, 4 * one, 0, 0, 0, 5 * one));
        send_request(mk(mx, mx, mx, one, one, 0, 0, 0, mx));
        send_request(mk(0, 0, 0, one, one, one, one, one, one));
        send_request(mk(neg1, neg1, neg1, 0, neg1, 0, 0, 0, neg1));
        send_request(mk(32'hffffffff, 1, 0, 0, 0, mn, one, 0, 0));
        set_coefs(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        send_request(mk(mx, mn, mx, one, 0, 0, 0, one, 0));
        send_request(mk(one, one, one, mx, mx, mx, mn, mn, mn));
        // unknown index must leave coefficients alone
        drain();
        write_reg(REG_NONE, 31'h0);
        send_request(mk(one, neg1, one, 0, one, 0, 0, 0, one));
        set_coefs(31'h0, 31'h0, 31'h0);
        send_request(mk(mx, mx, mx, one, 0, 0, 0, one, 0));
    endtask

    // Random requests over several coefficient settings.
    task automatic test_random(input int count);
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_coefs(31'($urandom), 31'($urandom), 31'($urandom));
                1: set_coefs(31'h7fffffff, 31'h0, 31'h01000000);
                2: set_coefs(31'h0, 31'h7fffffff, 31'h0);
                default: set_coefs(31'($urandom_range(0, 32'h04000000)),
                                   31'($urandom_range(0, 32'h04000000)),
                                   31'($urandom_range(0, 32'h04000000)));
            endcase
            burst_mode = (p == 4);
            for (int n = 0; n < count / 6; n++) send_request(rand_request());
            burst_mode = 1'b0;
        end
    endtask

    // Hold results off while requests keep coming so the input stalls,
    // then pause sending until every result is back.
    task automatic test_backpressure();
        set_coefs(31'($urandom), 31'($urandom), 31'($urandom));
        burst_mode = 1'b1;
        long_hold_req = 1'b1;
        for (int n = 0; n < 250; n++) send_request(rand_request());
        burst_mode = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (drag_expected.size() != 0) @(posedge aclk);
        for (int n = 0; n < 50; n++) send_request(rand_request());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(1200);
        test_backpressure();
        drain();
        $display("covered %0d requests, %0d results, %0d coefficient settings",
                 requests_sent, results_seen, cfg_phases);
        $display("including long output hold, bursts and idle pauses");
        if (errors == 0 && drag_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, drag_expected.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
